@@ sv/dss_pkg.sv @@
// dss_pkg: shared types, codes and widths for the dpwm strategy selector
// used by dss_front, dss_back and dpwm_strategy_selector_top
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

   localparam int ANGLE_IN_W = 15;
   localparam int ANGLE_W    = 17;
   localparam int CFG_ANG_W  = 14;
   localparam int TIME_W     = 32;
   localparam int SECTOR_W   = 4;
   localparam int STRAT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [STRAT_W-1:0] STRAT_DPWM0 = 3'd3;
   localparam logic [STRAT_W-1:0] STRAT_DPWM1 = 3'd4;
   localparam logic [STRAT_W-1:0] STRAT_DPWM2 = 3'd5;
   localparam logic [STRAT_W-1:0] STRAT_DPWM3 = 3'd6;

   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTER     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HYST      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DWELL     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOCK      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INIT      = 3'd5;

   localparam logic [CFG_ANG_W-1:0] DEADBAND_RESET = 14'd640;
   localparam logic [CFG_ANG_W-1:0] OUTER_RESET    = 14'd3840;
   localparam logic [CFG_ANG_W-1:0] HYST_RESET     = 14'd128;
   localparam logic [STRAT_W-1:0]   INIT_RESET     = 3'd4;
   localparam logic [SECTOR_W-1:0]  SECTOR_UNKNOWN = 4'hF;

   typedef struct packed {
      logic [CFG_ANG_W-1:0] deadband_angle;
      logic [CFG_ANG_W-1:0] outer_angle;
      logic [CFG_ANG_W-1:0] hysteresis_angle;
      logic [TIME_W-1:0]    min_dwell_ticks;
      logic                 sector_lock_enable;
      logic [STRAT_W-1:0]   initial_strategy;
   } cfg_type;

   typedef struct packed {
      logic                restart;
      logic [STRAT_W-1:0]  prop;
      logic                keep_dpwm0;
      logic                keep_dpwm1;
      logic                keep_dpwm2;
      logic [TIME_W-1:0]   time_stamp;
      logic [SECTOR_W-1:0] sector;
   } class_type;

   typedef struct packed {
      logic [STRAT_W-1:0] strategy;
      logic               switched;
   } result_type;

endpackage

`default_nettype wire

@@ sv/dpwm_strategy_selector_top.sv @@
// dpwm_strategy_selector_top: configuration registers and the front/back pair
// depends on dss_pkg, dss_front, dss_back
//
// channel  ports                                   transaction when
// req      push, full, req_* fields                push && !full
// rsp      empty, pop, rsp_* fields                pop && !empty
// csr      csr_we, csr_index, csr_wdata            csr_we
//
// one transaction per cycle sustained while neither queue stalls; a request passes the front
// queue register, then the result queue register, before it reaches the result ports
// the strategy state in dss_back is updated as each item is taken, so requests follow back to back
// synchronous reset restores register defaults and the initial strategy, empties both queues
// each side stalls on its own: two-entry queues sit between front, back and output
`timescale 1ns / 1ps
`default_nettype none

module dpwm_strategy_selector_top
   import dss_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic                         req_mode,
   input  wire logic                         req_pf_angle_valid,
   input  wire logic signed [ANGLE_IN_W-1:0] req_pf_angle,
   input  wire logic signed [ANGLE_IN_W-1:0] req_current_vector_angle,
   input  wire logic [TIME_W-1:0]            req_time_stamp,
   input  wire logic signed [SECTOR_W-1:0]   req_sector,
   output logic                              empty,
   input  wire logic                         pop,
   output logic [STRAT_W-1:0]                rsp_selected_strategy,
   output logic                              rsp_switched,
   input  wire logic                         csr_we,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_wdata
);

   cfg_type    cfg_ff;
   logic       item_valid;
   logic       item_take;
   class_type  item;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband_angle     <= DEADBAND_RESET;
         cfg_ff.outer_angle        <= OUTER_RESET;
         cfg_ff.hysteresis_angle   <= HYST_RESET;
         cfg_ff.min_dwell_ticks    <= '0;
         cfg_ff.sector_lock_enable <= 1'b0;
         cfg_ff.initial_strategy   <= INIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEADBAND: cfg_ff.deadband_angle     <= csr_wdata[CFG_ANG_W-1:0];
            REG_OUTER:    cfg_ff.outer_angle        <= csr_wdata[CFG_ANG_W-1:0];
            REG_HYST:     cfg_ff.hysteresis_angle   <= csr_wdata[CFG_ANG_W-1:0];
            REG_DWELL:    cfg_ff.min_dwell_ticks    <= csr_wdata[TIME_W-1:0];
            REG_LOCK:     cfg_ff.sector_lock_enable <= csr_wdata[0];
            REG_INIT:     cfg_ff.initial_strategy   <= csr_wdata[STRAT_W-1:0];
            default: ;
         endcase
      end
   end

   dss_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .push                 (push),
      .full                 (full),
      .mode                 (req_mode),
      .pf_angle_valid       (req_pf_angle_valid),
      .pf_angle             (req_pf_angle),
      .current_vector_angle (req_current_vector_angle),
      .time_stamp           (req_time_stamp),
      .sector               (req_sector),
      .item_valid           (item_valid),
      .item_take            (item_take),
      .item                 (item)
   );

   dss_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .empty      (empty),
      .pop        (pop),
      .result     (result)
   );

   assign rsp_selected_strategy = result.strategy;
   assign rsp_switched          = result.switched;

endmodule

`default_nettype wire

@@ sv/dss_front.sv @@
// dss_front: accepts request transactions, picks the angle and classifies it
// into a proposal and hysteresis flags; two-entry queue toward dss_back; uses dss_pkg
`timescale 1ns / 1ps
`default_nettype none

module dss_front
   import dss_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cfg_type                      cfg,
   input  wire logic                         push,
   output logic                              full,
   input  wire logic                         mode,
   input  wire logic                         pf_angle_valid,
   input  wire logic signed [ANGLE_IN_W-1:0] pf_angle,
   input  wire logic signed [ANGLE_IN_W-1:0] current_vector_angle,
   input  wire logic [TIME_W-1:0]            time_stamp,
   input  wire logic signed [SECTOR_W-1:0]   sector,
   output logic                              item_valid,
   input  wire logic                         item_take,
   output class_type                         item
);

   logic signed [ANGLE_W-1:0] phi;
   logic signed [ANGLE_W-1:0] mag;
   logic signed [ANGLE_W-1:0] db;
   logic signed [ANGLE_W-1:0] outer;
   logic signed [ANGLE_W-1:0] wide;
   class_type                 cls;
   class_type                 q_ff [2];
   logic                      wr_ptr_ff, wr_ptr_in;
   logic                      rd_ptr_ff, rd_ptr_in;
   logic [1:0]                count_ff, count_in;
   logic                      wr_en;

   always_comb begin
      if (pf_angle_valid) begin
         phi = {{(ANGLE_W-ANGLE_IN_W){pf_angle[ANGLE_IN_W-1]}}, pf_angle};
      end else begin
         phi = {{(ANGLE_W-ANGLE_IN_W){current_vector_angle[ANGLE_IN_W-1]}},
                current_vector_angle};
      end
      mag   = phi[ANGLE_W-1] ? -phi : phi;
      db    = {{(ANGLE_W-CFG_ANG_W){1'b0}}, cfg.deadband_angle};
      outer = {{(ANGLE_W-CFG_ANG_W){1'b0}}, cfg.outer_angle};
      wide  = db + {{(ANGLE_W-CFG_ANG_W){1'b0}}, cfg.hysteresis_angle};

      cls.restart    = mode;
      cls.time_stamp = time_stamp;
      cls.sector     = sector;
      if (mag <= db) begin
         cls.prop = STRAT_DPWM1;
      end else if (phi > 0 && phi <= outer) begin
         cls.prop = STRAT_DPWM2;
      end else if (phi < 0 && phi >= -outer) begin
         cls.prop = STRAT_DPWM0;
      end else begin
         cls.prop = STRAT_DPWM3;
      end
      cls.keep_dpwm1 = (mag <= wide);
      cls.keep_dpwm2 = (phi > 0) && (phi <= wide);
      cls.keep_dpwm0 = (phi < 0) && (phi >= -wide);
   end

   // queue control
   assign full       = (count_ff == 2'd2);
   assign wr_en      = push && !full;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ (item_take && item_valid);
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, item_take && item_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

@@ sv/dss_back.sv @@
// dss_back: holds the strategy state, applies hysteresis, dwell and sector lock,
// and queues results in two entries; uses dss_pkg
`timescale 1ns / 1ps
`default_nettype none

module dss_back
   import dss_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        item_valid,
   output logic             item_take,
   input  wire class_type   item,
   output logic             empty,
   input  wire logic        pop,
   output result_type       result
);

   logic [STRAT_W-1:0]  cur_ff, cur_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic                has_sw_ff, has_sw_in;
   logic [SECTOR_W-1:0] last_sec_ff, last_sec_in;
   logic [STRAT_W-1:0]  prop;
   logic [TIME_W-1:0]   elapsed;
   logic                locked;
   logic                may_switch;
   result_type          res;
   result_type          q_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                rd_en;

   assign rd_en     = pop && (count_ff != 2'd0);
   assign item_take = item_valid && ((count_ff != 2'd2) || rd_en);
   assign empty     = (count_ff == 2'd0);
   assign result    = q_ff[rd_ptr_ff];

   always_comb begin
      if (cur_ff == item.prop) begin
         prop = item.prop;
      end else if (cur_ff == STRAT_DPWM1 && item.keep_dpwm1) begin
         prop = cur_ff;
      end else if (cur_ff == STRAT_DPWM2 && item.keep_dpwm2) begin
         prop = cur_ff;
      end else if (cur_ff == STRAT_DPWM0 && item.keep_dpwm0) begin
         prop = cur_ff;
      end else begin
         prop = item.prop;
      end

      elapsed    = item.time_stamp - last_time_ff;
      locked     = cfg.sector_lock_enable && !item.sector[SECTOR_W-1] &&
                   !last_sec_ff[SECTOR_W-1] && (item.sector == last_sec_ff);
      may_switch = !has_sw_ff || (!locked && (elapsed >= cfg.min_dwell_ticks));

      cur_in       = cur_ff;
      last_time_in = last_time_ff;
      has_sw_in    = has_sw_ff;
      last_sec_in  = last_sec_ff;
      if (item.restart) begin
         cur_in       = cfg.initial_strategy;
         last_time_in = '0;
         has_sw_in    = 1'b0;
         last_sec_in  = SECTOR_UNKNOWN;
      end else if (may_switch && prop != cur_ff) begin
         cur_in       = prop;
         last_time_in = item.time_stamp;
         has_sw_in    = 1'b1;
         last_sec_in  = item.sector;
      end
      res.strategy = cur_in;
      res.switched = (cur_in != cur_ff);

      wr_ptr_in = wr_ptr_ff ^ item_take;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, item_take} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= INIT_RESET;
         last_time_ff <= '0;
         has_sw_ff    <= 1'b0;
         last_sec_ff  <= SECTOR_UNKNOWN;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
      end else begin
         if (item_take) begin
            cur_ff       <= cur_in;
            last_time_ff <= last_time_in;
            has_sw_ff    <= has_sw_in;
            last_sec_ff  <= last_sec_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (item_take) begin
         q_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_dpwm_strategy_selector_top.sv @@
// tb_dpwm_strategy_selector_top: self-checking bench for the dpwm strategy selector,
// directed zone, dwell, lock and restart tests, then randomized traffic with stalls
// depends on dss_pkg and dpwm_strategy_selector_top
`timescale 1ns / 1ps

module tb_dpwm_strategy_selector_top;
   import dss_pkg::*;

   localparam logic                 MODE_DECIDE    = 1'b0;
   localparam logic                 MODE_RESTART   = 1'b1;
   localparam logic [STRAT_W-1:0]   STRAT_SVPWM    = 3'd0;
   localparam logic [STRAT_W-1:0]   STRAT_DPWMMIN  = 3'd1;
   localparam logic [STRAT_W-1:0]   STRAT_DPWMMAX  = 3'd2;
   localparam logic [STRAT_W-1:0]   STRAT_FIRMWARE = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI   = 3'd7;
   localparam int                   IDLE_MAX       = 18;
   localparam int                   CYCLE_LIMIT    = 200000;

   typedef struct {
      logic                         mode;
      logic                         pf_valid;
      logic signed [ANGLE_IN_W-1:0] pf_angle;
      logic signed [ANGLE_IN_W-1:0] cv_angle;
      logic [TIME_W-1:0]            time_stamp;
      logic signed [SECTOR_W-1:0]   sector;
   } angle_req_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         push = 1'b0;
   logic                         full;
   logic                         req_mode = 1'b0;
   logic                         req_pf_angle_valid = 1'b0;
   logic signed [ANGLE_IN_W-1:0] req_pf_angle = '0;
   logic signed [ANGLE_IN_W-1:0] req_current_vector_angle = '0;
   logic [TIME_W-1:0]            req_time_stamp = '0;
   logic signed [SECTOR_W-1:0]   req_sector = '0;
   logic                         empty;
   logic                         pop = 1'b0;
   logic [STRAT_W-1:0]           rsp_selected_strategy;
   logic                         rsp_switched;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // predictor copy of configuration and strategy state
   cfg_type            model_cfg;
   logic [STRAT_W-1:0] cur_strategy;
   logic [TIME_W-1:0]  last_switch_time;
   bit                 has_switched;
   int                 last_switch_sector;

   result_type         expected_strategy_q[$];
   int                 mismatches = 0;
   int                 cycle_count = 0;
   bit                 tx_idle_on = 1'b1;
   bit                 rx_idle_on = 1'b1;
   logic               rx_hold = 1'b0;
   int                 rx_wait = 0;
   logic [TIME_W-1:0]  tick_now = 32'hFFFF_F000;

   dpwm_strategy_selector_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .push                     (push),
      .full                     (full),
      .req_mode                 (req_mode),
      .req_pf_angle_valid       (req_pf_angle_valid),
      .req_pf_angle             (req_pf_angle),
      .req_current_vector_angle (req_current_vector_angle),
      .req_time_stamp           (req_time_stamp),
      .req_sector               (req_sector),
      .empty                    (empty),
      .pop                      (pop),
      .rsp_selected_strategy    (rsp_selected_strategy),
      .rsp_switched             (rsp_switched),
      .csr_we                   (csr_we),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------- predictor ----------------

   task automatic restart_strategy();
      cur_strategy       = model_cfg.initial_strategy;
      last_switch_time   = '0;
      has_switched       = 1'b0;
      last_switch_sector = -1;
   endtask

   task automatic reset_predictor();
      model_cfg.deadband_angle     = DEADBAND_RESET;
      model_cfg.outer_angle        = OUTER_RESET;
      model_cfg.hysteresis_angle   = HYST_RESET;
      model_cfg.min_dwell_ticks    = '0;
      model_cfg.sector_lock_enable = 1'b0;
      model_cfg.initial_strategy   = INIT_RESET;
      restart_strategy();
   endtask

   function automatic logic [STRAT_W-1:0] zone_strategy(int phi);
      int mag;
      mag = (phi < 0) ? -phi : phi;
      if (mag <= int'(model_cfg.deadband_angle))
         return STRAT_DPWM1;
      if (phi > 0 && phi <= int'(model_cfg.outer_angle))
         return STRAT_DPWM2;
      if (phi < 0 && phi >= -int'(model_cfg.outer_angle))
         return STRAT_DPWM0;
      return STRAT_DPWM3;
   endfunction

   function automatic logic [STRAT_W-1:0] hold_strategy(logic [STRAT_W-1:0] prop, int phi);
      int wide;
      int mag;
      wide = int'(model_cfg.deadband_angle) + int'(model_cfg.hysteresis_angle);
      mag  = (phi < 0) ? -phi : phi;
      if (cur_strategy == prop)
         return prop;
      if (cur_strategy == STRAT_DPWM1 && mag <= wide)
         return cur_strategy;
      if (cur_strategy == STRAT_DPWM2 && phi > 0 && phi <= wide)
         return cur_strategy;
      if (cur_strategy == STRAT_DPWM0 && phi < 0 && phi >= -wide)
         return cur_strategy;
      return prop;
   endfunction

   task automatic predict_strategy(input angle_req_type r, output result_type res);
      logic [STRAT_W-1:0] prior;
      logic [STRAT_W-1:0] prop;
      logic [TIME_W-1:0]  elapsed;
      int                 phi;
      int                 sec;
      bit                 allowed;
      prior = cur_strategy;
      if (r.mode == MODE_RESTART) begin
         restart_strategy();
      end else begin
         phi     = r.pf_valid ? int'(r.pf_angle) : int'(r.cv_angle);
         sec     = int'(r.sector);
         prop    = hold_strategy(zone_strategy(phi), phi);
         elapsed = r.time_stamp - last_switch_time;
         if (!has_switched)
            allowed = 1'b1;
         else if (model_cfg.sector_lock_enable && sec >= 0 && last_switch_sector >= 0 &&
                  sec == last_switch_sector)
            allowed = 1'b0;
         else
            allowed = (elapsed >= model_cfg.min_dwell_ticks);
         if (allowed && prop != cur_strategy) begin
            cur_strategy       = prop;
            last_switch_time   = r.time_stamp;
            has_switched       = 1'b1;
            last_switch_sector = sec;
         end
      end
      res.strategy = cur_strategy;
      res.switched = (cur_strategy != prior);
   endtask

   // ---------------- drivers ----------------

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_DEADBAND: model_cfg.deadband_angle     = value[CFG_ANG_W-1:0];
         REG_OUTER:    model_cfg.outer_angle        = value[CFG_ANG_W-1:0];
         REG_HYST:     model_cfg.hysteresis_angle   = value[CFG_ANG_W-1:0];
         REG_DWELL:    model_cfg.min_dwell_ticks    = value[TIME_W-1:0];
         REG_LOCK:     model_cfg.sector_lock_enable = value[0];
         REG_INIT:     model_cfg.initial_strategy   = value[STRAT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input int db, input int outer, input int hyst,
                                input logic [TIME_W-1:0] dwell, input logic lock,
                                input logic [STRAT_W-1:0] init);
      write_reg(REG_DEADBAND, db);
      write_reg(REG_OUTER, outer);
      write_reg(REG_HYST, hyst);
      write_reg(REG_DWELL, dwell);
      write_reg(REG_LOCK, {31'd0, lock});
      write_reg(REG_INIT, {29'd0, init});
   endtask

   task automatic send_req(input angle_req_type r);
      int         gap;
      result_type res;
      gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push                     <= 1'b1;
      req_mode                 <= r.mode;
      req_pf_angle_valid       <= r.pf_valid;
      req_pf_angle             <= r.pf_angle;
      req_current_vector_angle <= r.cv_angle;
      req_time_stamp           <= r.time_stamp;
      req_sector               <= r.sector;
      do @(posedge clock); while (full);
      predict_strategy(r, res);
      expected_strategy_q.push_back(res);
   endtask

   task automatic drain();
      push <= 1'b0;
      do @(posedge clock); while (expected_strategy_q.size() != 0);
   endtask

   function automatic angle_req_type decide(logic pfv, int pf, int cv, logic [TIME_W-1:0] ts,
                                            int sec);
      angle_req_type r;
      r.mode       = MODE_DECIDE;
      r.pf_valid   = pfv;
      r.pf_angle   = pf;
      r.cv_angle   = cv;
      r.time_stamp = ts;
      r.sector     = sec;
      return r;
   endfunction

   function automatic angle_req_type restart_req();
      angle_req_type r;
      r = decide(1'b0, 0, 0, '0, -1);
      r.mode = MODE_RESTART;
      return r;
   endfunction

   function automatic int pick_angle();
      int sel;
      int edge_val;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         case ($urandom_range(0, 2))
            0: edge_val = model_cfg.deadband_angle;
            1: edge_val = model_cfg.outer_angle;
            default: edge_val = int'(model_cfg.deadband_angle) + int'(model_cfg.hysteresis_angle);
         endcase
         edge_val = edge_val + $urandom_range(0, 4) - 2;
         if ($urandom_range(0, 1))
            edge_val = -edge_val;
         if (edge_val > 16383)
            edge_val = 16383;
         if (edge_val < -16384)
            edge_val = -16384;
         return edge_val;
      end
      if (sel < 9)
         return int'($urandom_range(0, 23040)) - 11520;
      return int'($signed($urandom() & 32'h7FFF) << 17) >>> 17;
   endfunction

   function automatic angle_req_type random_req();
      angle_req_type r;
      int            sel;
      if ($urandom_range(0, 39) == 0)
         tick_now = $urandom();
      else
         tick_now = tick_now + $urandom_range(0, 40);
      sel = $urandom_range(0, 9);
      r = decide($urandom_range(0, 1), pick_angle(), pick_angle(), tick_now,
                 (sel == 0) ? int'($urandom_range(0, 15)) :
                 (sel == 1) ? -1 : int'($urandom_range(0, 7)));
      if (sel == 0)
         r.sector = $urandom_range(0, 15);
      if ($urandom_range(0, 29) == 0)
         r.mode = MODE_RESTART;
      return r;
   endfunction

   // ---------------- result checking ----------------

   always @(posedge clock) begin : rsp_check
      result_type exp;
      if (reset) begin
         pop     <= 1'b0;
         rx_wait = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_strategy_q.size() == 0) begin
               if (mismatches < 10)
                  $display("mismatch: unexpected transaction, strategy %0d switched %0d",
                           rsp_selected_strategy, rsp_switched);
               mismatches++;
            end else begin
               exp = expected_strategy_q.pop_front();
               if (rsp_selected_strategy !== exp.strategy || rsp_switched !== exp.switched) begin
                  if (mismatches < 10)
                     $display("mismatch cyc %0d: strat exp %0d got %0d, sw exp %0d got %0d",
                              cycle_count, exp.strategy, rsp_selected_strategy,
                              exp.switched, rsp_switched);
                  mismatches++;
               end
            end
            rx_wait = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (rx_hold) begin
            pop <= 1'b0;
         end else if (rx_wait != 0) begin
            pop <= 1'b0;
            rx_wait--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_zone_edges();
      send_req(decide(1'b1, 0, -11520, '0, -1));
      send_req(decide(1'b0, 0, 768, '0, -1));
      send_req(decide(1'b0, 0, 769, '0, -1));
      send_req(decide(1'b0, 0, 640, '0, -1));
      send_req(decide(1'b0, 0, 0, '0, -1));
      send_req(decide(1'b0, 0, -769, '0, -1));
      send_req(decide(1'b0, 0, -3841, '0, -1));
      send_req(decide(1'b1, 3840, 11520, '0, -1));
      send_req(decide(1'b1, -16384, 0, '0, -1));
      send_req(decide(1'b1, 16383, 0, '0, -1));
      send_req(restart_req());
      send_req(restart_req());
      drain();
   endtask

   task automatic test_dwell_and_lock();
      load_settings(640, 3840, 128, 100, 1'b1, STRAT_DPWM1);
      send_req(restart_req());
      send_req(decide(1'b0, 0, 2000, 1000, 2));
      send_req(decide(1'b0, 0, 0, 1050, 3));
      send_req(decide(1'b0, 0, 0, 1100, 2));
      send_req(decide(1'b0, 0, 0, 1100, -8));
      send_req(restart_req());
      send_req(decide(1'b0, 0, -2000, 32'hFFFF_FFC0, 1));
      send_req(decide(1'b0, 0, 0, 32'h0000_0030, 2));
      drain();
   endtask

   task automatic test_restart_strategies();
      logic [STRAT_W-1:0] inits[4];
      inits = '{STRAT_SVPWM, STRAT_DPWMMIN, STRAT_DPWMMAX, STRAT_FIRMWARE};
      write_reg(REG_LOCK, '0);
      foreach (inits[i]) begin
         write_reg(REG_INIT, {29'd0, inits[i]});
         send_req(restart_req());
         send_req(decide(1'b0, 0, 700, 5000, -1));
         drain();
      end
      write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
   endtask

   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      fork
         begin
            rx_hold <= 1'b1;
            repeat (150) @(posedge clock);
            rx_hold <= 1'b0;
         end
      join_none
      repeat (24) send_req(random_req());
      drain();
      tx_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [TIME_W-1:0] dwell;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: load_settings(0, 0, 0, '0, 1'b0, $urandom_range(0, 7));
            1: load_settings(16383, 16383, 16383, 32'hFFFF_FFFF, 1'b1, $urandom_range(0, 7));
            2: load_settings(11520, 11520, 11520, '0, 1'b1, $urandom_range(0, 7));
            default: begin
               case ($urandom_range(0, 3))
                  0: dwell = '0;
                  1: dwell = $urandom_range(1, 200);
                  2: dwell = $urandom_range(0, 60);
                  default: dwell = $urandom();
               endcase
               load_settings($urandom_range(0, 2000), $urandom_range(0, 8000),
                             $urandom_range(0, 600), dwell, $urandom_range(0, 1),
                             $urandom_range(0, 7));
            end
         endcase
         tx_idle_on = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         rx_idle_on = (phase == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         repeat (50) send_req(random_req());
         drain();
      end
   endtask

   initial begin
      reset_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zone_edges();
      test_dwell_and_lock();
      test_restart_strategies();
      test_backpressure();
      test_random_traffic();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_strategy_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
sv/dss_pkg.sv
sv/dss_front.sv
sv/dss_back.sv
sv/dpwm_strategy_selector_top.sv
verif/tb_dpwm_strategy_selector_top.sv
